// ===== src/wavhp_pkg.sv =====
// ----------------------------------------------------------------------------
// wavhp_pkg
// Shared types, codes and constants of the RIFF/WAVE PCM header parser.
// ----------------------------------------------------------------------------
package wavhp_pkg;

  localparam int unsigned ByteW    = 8;
  localparam int unsigned WordW    = 32;
  localparam int unsigned HalfW    = 16;
  localparam int unsigned KindW    = 2;
  localparam int unsigned ErrW     = 4;
  localparam int unsigned PhaseW   = 4;
  localparam int unsigned DivSteps = WordW;

  typedef logic [KindW-1:0] kind_t;
  typedef logic [ErrW-1:0]  err_t;

  localparam kind_t KIND_HEADER = 2'd0;
  localparam kind_t KIND_SAMPLE = 2'd1;
  localparam kind_t KIND_ERROR  = 2'd2;

  localparam err_t ERR_OK        = 4'd0;
  localparam err_t ERR_RIFF      = 4'd1;
  localparam err_t ERR_SIZE      = 4'd2;
  localparam err_t ERR_WAVE      = 4'd3;
  localparam err_t ERR_FMT       = 4'd4;
  localparam err_t ERR_NOT_PCM   = 4'd5;
  localparam err_t ERR_DATA_TAG  = 4'd6;
  localparam err_t ERR_ZERO_BPS  = 4'd7;
  localparam err_t ERR_FMT_SMALL = 4'd8;

  localparam logic [WordW-1:0] TAG_RIFF = 32'h4646_4952;
  localparam logic [WordW-1:0] TAG_WAVE = 32'h4556_4157;
  localparam logic [WordW-1:0] TAG_FMT  = 32'h2074_6D66;
  localparam logic [WordW-1:0] TAG_DATA = 32'h6174_6164;
  localparam logic [WordW-1:0] RIFF_HDR_ADD = 32'd8;
  localparam logic [WordW-1:0] FMT_BASE_LEN = 32'd16;
  localparam logic [WordW-1:0] PCM_FORMAT   = 32'd1;

  // register byte addresses
  localparam logic [2:0] ADDR_FILE_SIZE = 3'd0;

endpackage

// ===== src/wavhp_in_if.sv =====
// ----------------------------------------------------------------------------
// wavhp_in_if
// Byte stream channel into the parser: one file byte per beat.
// ----------------------------------------------------------------------------
interface wavhp_in_if;
  import wavhp_pkg::*;

  logic              valid;
  logic              ready;
  logic [ByteW-1:0]  data_byte;
  logic              first_byte;

  modport source (output valid, data_byte, first_byte, input ready);
  modport sink   (input valid, data_byte, first_byte, output ready);

endinterface

// ===== src/wavhp_out_if.sv =====
// ----------------------------------------------------------------------------
// wavhp_out_if
// Result channel of the parser: header, sample or error per beat.
// ----------------------------------------------------------------------------
interface wavhp_out_if;
  import wavhp_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [KindW-1:0]         result_kind;
  logic [ErrW-1:0]          error_code;
  logic [HalfW-1:0]         channels;
  logic [WordW-1:0]         rate_hz;
  logic [WordW-1:0]         samples_total;
  logic signed [HalfW-1:0]  sample_value;
  logic                     last_sample;

  modport source (output valid, result_kind, error_code, channels, rate_hz,
                  samples_total, sample_value, last_sample, input ready);
  modport sink   (input valid, result_kind, error_code, channels, rate_hz,
                  samples_total, sample_value, last_sample, output ready);

endinterface

// ===== src/wav_header_parser.sv =====
// ----------------------------------------------------------------------------
// wav_header_parser
// RIFF/WAVE PCM header parser with sample extraction.
// ----------------------------------------------------------------------------
// Takes a file one byte per beat on in_i (first_byte restarts parsing) and
// returns one header beat with channels, rate and sample count, then the
// signed 16-bit samples with last_sample on the final one, or a single error
// beat on the first failed check. A byte is taken whenever the output register is
// free, except after the last byte of the data size: the sample count comes from
// a one-bit-per-cycle restoring divider, and in_i.ready stays low while it runs.
// file_size (APB byte address 0) must be written while the block is idle.
// ----------------------------------------------------------------------------
module wav_header_parser (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  wavhp_in_if.sink                   in_i,
  wavhp_out_if.source                out_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [2:0]                 paddr,
  input  logic [wavhp_pkg::WordW-1:0] pwdata,
  output logic [wavhp_pkg::WordW-1:0] prdata,
  output logic                       pready
);
  import wavhp_pkg::*;

  localparam logic [PhaseW-1:0] PH_RIFF    = 4'd0;
  localparam logic [PhaseW-1:0] PH_CSIZE   = 4'd1;
  localparam logic [PhaseW-1:0] PH_WAVE    = 4'd2;
  localparam logic [PhaseW-1:0] PH_FMTTAG  = 4'd3;
  localparam logic [PhaseW-1:0] PH_FMTLEN  = 4'd4;
  localparam logic [PhaseW-1:0] PH_FORMAT  = 4'd5;
  localparam logic [PhaseW-1:0] PH_CHAN    = 4'd6;
  localparam logic [PhaseW-1:0] PH_RATE    = 4'd7;
  localparam logic [PhaseW-1:0] PH_BRATE   = 4'd8;
  localparam logic [PhaseW-1:0] PH_ALIGN   = 4'd9;
  localparam logic [PhaseW-1:0] PH_BITS    = 4'd10;
  localparam logic [PhaseW-1:0] PH_SKIP    = 4'd11;
  localparam logic [PhaseW-1:0] PH_DTAG    = 4'd12;
  localparam logic [PhaseW-1:0] PH_DSIZE   = 4'd13;
  localparam logic [PhaseW-1:0] PH_SAMPLES = 4'd14;
  localparam logic [PhaseW-1:0] PH_IDLE    = 4'd15;

  localparam int unsigned BpsW  = HalfW - 3;
  localparam int unsigned DcntW = $clog2(DivSteps);

  // configuration
  logic [WordW-1:0] file_size_q;

  // parser state
  logic [PhaseW-1:0] phase_q, phase_d;
  logic [1:0]        off_q, off_d;
  logic [WordW-1:0]  acc_q, acc_d;
  logic [WordW-1:0]  fmt_len_q, fmt_len_d;
  logic [HalfW-1:0]  chan_q, chan_d;
  logic [WordW-1:0]  rate_q, rate_d;
  logic [HalfW-1:0]  bits_q, bits_d;
  logic [WordW-1:0]  left_q, left_d;   // dividend/quotient during the divide
  logic [ByteW-1:0]  hold_q, hold_d;

  // divider
  logic              busy_q, busy_d;
  logic [DcntW-1:0]  dcnt_q, dcnt_d;
  logic [BpsW-1:0]   rem_q, rem_d;

  // output register
  logic                    ovalid_q, ovalid_d;
  logic [KindW-1:0]        okind_q, okind_d;
  logic [ErrW-1:0]         oerr_q, oerr_d;
  logic [HalfW-1:0]        ochan_q, ochan_d;
  logic [WordW-1:0]        orate_q, orate_d;
  logic [WordW-1:0]        ototal_q, ototal_d;
  logic signed [HalfW-1:0] oval_q, oval_d;
  logic                    olast_q, olast_d;

  logic              accept;
  logic              cfg_wr;
  logic [PhaseW-1:0] cur_phase;
  logic [1:0]        cur_off;
  logic [WordW-1:0]  cur_acc;
  logic [WordW-1:0]  field_v;
  logic [1:0]        last_off;
  logic              field_done;
  logic [BpsW-1:0]   bps;
  logic [BpsW:0]     rem_sh;
  logic [BpsW+1:0]   rem_diff;
  logic              q_bit;
  logic [WordW-1:0]  left_dec;
  logic [WordW-1:0]  fmt_dec;

  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_FILE_SIZE) ? file_size_q : '0;
  assign cfg_wr = psel & penable & pwrite;

  assign in_i.ready = ~busy_q & (~ovalid_q | out_o.ready);
  assign accept     = in_i.valid & in_i.ready;

  // first_byte restarts parsing on this very beat
  assign cur_phase = in_i.first_byte ? PH_RIFF : phase_q;
  assign cur_off   = in_i.first_byte ? 2'd0 : off_q;
  assign cur_acc   = in_i.first_byte ? '0 : acc_q;

  assign field_v = cur_acc | (WordW'(in_i.data_byte) << {cur_off, 3'b000});

  always_comb begin
    unique case (cur_phase)
      PH_FORMAT, PH_CHAN, PH_ALIGN, PH_BITS: last_off = 2'd1;
      default:                               last_off = 2'd3;
    endcase
  end
  assign field_done = (cur_off == last_off);

  // restoring divide step: quotient bits shift into left_q
  assign bps      = bits_q[HalfW-1:3];
  assign rem_sh   = {rem_q, left_q[WordW-1]};
  assign rem_diff = {1'b0, rem_sh} - {2'b00, bps};
  assign q_bit    = ~rem_diff[BpsW+1];

  assign left_dec = left_q - 1'b1;
  assign fmt_dec  = fmt_len_q - 1'b1;

  always_comb begin
    phase_d   = phase_q;
    off_d     = off_q;
    acc_d     = acc_q;
    fmt_len_d = fmt_len_q;
    chan_d    = chan_q;
    rate_d    = rate_q;
    bits_d    = bits_q;
    left_d    = left_q;
    hold_d    = hold_q;
    busy_d    = busy_q;
    dcnt_d    = dcnt_q;
    rem_d     = rem_q;

    ovalid_d = ovalid_q & ~out_o.ready;
    okind_d  = okind_q;
    oerr_d   = oerr_q;
    ochan_d  = ochan_q;
    orate_d  = orate_q;
    ototal_d = ototal_q;
    oval_d   = oval_q;
    olast_d  = olast_q;

    if (busy_q) begin
      rem_d  = q_bit ? rem_diff[BpsW-1:0] : rem_sh[BpsW-1:0];
      left_d = {left_q[WordW-2:0], q_bit};
      dcnt_d = dcnt_q + 1'b1;
      if (dcnt_q == DcntW'(DivSteps - 1)) begin
        busy_d   = 1'b0;
        phase_d  = ({left_q[WordW-2:0], q_bit} == '0) ? PH_IDLE : PH_SAMPLES;
        ovalid_d = 1'b1;
        okind_d  = KIND_HEADER;
        oerr_d   = ERR_OK;
        ochan_d  = chan_q;
        orate_d  = rate_q;
        ototal_d = {left_q[WordW-2:0], q_bit};
        oval_d   = '0;
        olast_d  = 1'b0;
      end
    end else if (accept) begin
      phase_d = cur_phase;
      off_d   = cur_off;
      acc_d   = cur_acc;
      unique case (cur_phase)
        PH_IDLE: begin
        end
        PH_SKIP: begin
          fmt_len_d = fmt_dec;
          if (fmt_dec == '0) begin
            phase_d = PH_DTAG;
          end
        end
        PH_SAMPLES: begin
          if (!cur_off[0]) begin
            hold_d = in_i.data_byte;
            off_d  = 2'd1;
          end else begin
            off_d    = 2'd0;
            left_d   = left_dec;
            ovalid_d = 1'b1;
            okind_d  = KIND_SAMPLE;
            oerr_d   = ERR_OK;
            ochan_d  = '0;
            orate_d  = '0;
            ototal_d = '0;
            oval_d   = {in_i.data_byte, hold_q};
            olast_d  = (left_dec == '0);
            if (left_dec == '0) begin
              phase_d = PH_IDLE;
            end
          end
        end
        default: begin
          if (!field_done) begin
            acc_d = field_v;
            off_d = cur_off + 1'b1;
          end else begin
            acc_d   = '0;
            off_d   = 2'd0;
            phase_d = cur_phase + 1'b1;
            oerr_d  = ERR_OK;
            unique case (cur_phase)
              PH_RIFF:   if (field_v != TAG_RIFF) oerr_d = ERR_RIFF;
              PH_CSIZE:  if (field_v + RIFF_HDR_ADD != file_size_q) oerr_d = ERR_SIZE;
              PH_WAVE:   if (field_v != TAG_WAVE) oerr_d = ERR_WAVE;
              PH_FMTTAG: if (field_v != TAG_FMT) oerr_d = ERR_FMT;
              PH_FMTLEN: begin
                fmt_len_d = field_v;
                if (field_v < FMT_BASE_LEN) oerr_d = ERR_FMT_SMALL;
              end
              PH_FORMAT: if (field_v != PCM_FORMAT) oerr_d = ERR_NOT_PCM;
              PH_CHAN:   chan_d = field_v[HalfW-1:0];
              PH_RATE:   rate_d = field_v;
              PH_BITS: begin
                bits_d    = field_v[HalfW-1:0];
                fmt_len_d = fmt_len_q - FMT_BASE_LEN;
                phase_d   = (fmt_len_q == FMT_BASE_LEN) ? PH_DTAG : PH_SKIP;
              end
              PH_DTAG:   if (field_v != TAG_DATA) oerr_d = ERR_DATA_TAG;
              PH_DSIZE: begin
                if (bps == '0) begin
                  oerr_d = ERR_ZERO_BPS;
                end else begin
                  // header goes out when the divide finishes
                  phase_d = PH_DSIZE;
                  busy_d  = 1'b1;
                  dcnt_d  = '0;
                  rem_d   = '0;
                  left_d  = field_v;
                end
              end
              default: begin
              end
            endcase
            if (oerr_d != ERR_OK) begin
              phase_d  = PH_IDLE;
              ovalid_d = 1'b1;
              okind_d  = KIND_ERROR;
              ochan_d  = '0;
              orate_d  = '0;
              ototal_d = '0;
              oval_d   = '0;
              olast_d  = 1'b0;
            end else begin
              oerr_d = oerr_q;
            end
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      file_size_q <= '0;
      phase_q     <= PH_RIFF;
      off_q       <= '0;
      acc_q       <= '0;
      busy_q      <= 1'b0;
      dcnt_q      <= '0;
      ovalid_q    <= 1'b0;
    end else begin
      if (cfg_wr && paddr == ADDR_FILE_SIZE) begin
        file_size_q <= pwdata;
      end
      phase_q  <= phase_d;
      off_q    <= off_d;
      acc_q    <= acc_d;
      busy_q   <= busy_d;
      dcnt_q   <= dcnt_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    fmt_len_q <= fmt_len_d;
    chan_q    <= chan_d;
    rate_q    <= rate_d;
    bits_q    <= bits_d;
    left_q    <= left_d;
    hold_q    <= hold_d;
    rem_q     <= rem_d;
    okind_q   <= okind_d;
    oerr_q    <= oerr_d;
    ochan_q   <= ochan_d;
    orate_q   <= orate_d;
    ototal_q  <= ototal_d;
    oval_q    <= oval_d;
    olast_q   <= olast_d;
  end

  assign out_o.valid         = ovalid_q;
  assign out_o.result_kind   = okind_q;
  assign out_o.error_code    = oerr_q;
  assign out_o.channels      = ochan_q;
  assign out_o.rate_hz       = orate_q;
  assign out_o.samples_total = ototal_q;
  assign out_o.sample_value  = oval_q;
  assign out_o.last_sample   = olast_q;

endmodule
